@@ rtl/bcd_pkg.sv @@
// Shared types and constants of the button click detector.
`timescale 1ns / 1ps
package bcd_pkg;

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_BLOCK = 3'd1,
    MODE_BTIME = 3'd2,
    MODE_FETCH = 3'd3,
    MODE_QUERY = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    MSG_NONE   = 2'd0,
    MSG_CLICK  = 2'd1,
    MSG_DOUBLE = 2'd2
  } msg_t;

  localparam logic [15:0] DBL_WINDOW_RESET = 16'd200;
  localparam int unsigned LEVEL_BITS = 8;

  typedef struct packed {
    logic        tick;
    logic        level;
    logic [15:0] dt;
    logic [15:0] window;
    logic        set_once;
    logic        load_blk;
    logic [31:0] blk;
    logic        clr_msg;
  } lane_ctrl_t;

  typedef struct packed {
    logic [7:0]  pressed_mask;
    msg_t        msg_code;
    logic [2:0]  msg_pin;
    logic [31:0] press_ticks_now;
    logic [31:0] press_ticks_last;
  } result_t;

endpackage

@@ rtl/bcd_in_if.sv @@
// Input channel of the button click detector: tick and command beats.
`timescale 1ns / 1ps
interface bcd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] elapsed_ticks;
  logic [7:0]  pressed_levels;
  logic [2:0]  pin_index;
  logic [31:0] block_ticks;

  modport source (
    output valid, mode, elapsed_ticks, pressed_levels, pin_index, block_ticks,
    input  ready
  );
  modport sink (
    input  valid, mode, elapsed_ticks, pressed_levels, pin_index, block_ticks,
    output ready
  );
endinterface

@@ rtl/bcd_out_if.sv @@
// Result channel of the button click detector.
`timescale 1ns / 1ps
interface bcd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pressed_mask;
  logic [1:0]  msg_code;
  logic [2:0]  msg_pin;
  logic [31:0] press_ticks_now;
  logic [31:0] press_ticks_last;

  modport source (
    output valid, pressed_mask, msg_code, msg_pin, press_ticks_now, press_ticks_last,
    input  ready
  );
  modport sink (
    input  valid, pressed_mask, msg_code, msg_pin, press_ticks_now, press_ticks_last,
    output ready
  );
endinterface

@@ rtl/bcd_lane.sv @@
// Per-button lane: press, release and block timers and the posted message.
`timescale 1ns / 1ps
module bcd_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  bcd_pkg::lane_ctrl_t ctrl,
  output bcd_pkg::msg_t      msg_o,
  output logic [31:0]        press_o,
  output logic [31:0]        last_o
);

  logic [31:0]    press_r, press_nxt;
  logic [31:0]    rel_r, rel_nxt;
  logic [31:0]    last_r, last_nxt;
  logic [31:0]    sup_r, sup_nxt;
  logic           prev_r, prev_nxt;
  logic           once_r, once_nxt;
  bcd_pkg::msg_t  msg_r, msg_nxt;

  logic [31:0]    dt32;
  logic [31:0]    sup_dec;
  logic [32:0]    press_sum;
  logic [32:0]    rel_sum;
  logic           edge_seen;
  bcd_pkg::msg_t  edge_msg;

  assign dt32      = {16'd0, ctrl.dt};
  assign sup_dec   = (sup_r > dt32) ? (sup_r - dt32) : 32'd0;
  assign press_sum = {1'b0, press_r} + {17'd0, ctrl.dt};
  assign rel_sum   = {1'b0, rel_r} + {17'd0, ctrl.dt};
  assign edge_seen = ctrl.level != prev_r;

  always_comb begin
    // Pick the message an edge posts before suppression.
    if (ctrl.level) begin
      if ((rel_r != 32'd0) && (rel_r < {16'd0, ctrl.window})) begin
        edge_msg = bcd_pkg::MSG_DOUBLE;
      end else begin
        edge_msg = bcd_pkg::MSG_NONE;
      end
    end else begin
      edge_msg = bcd_pkg::MSG_CLICK;
    end
    if (once_r || (sup_dec != 32'd0)) begin
      edge_msg = bcd_pkg::MSG_NONE;
    end
  end

  always_comb begin
    press_nxt = press_r;
    rel_nxt   = rel_r;
    last_nxt  = last_r;
    sup_nxt   = sup_r;
    prev_nxt  = prev_r;
    once_nxt  = once_r;
    msg_nxt   = msg_r;
    if (ctrl.tick) begin
      sup_nxt = sup_dec;
      if (edge_seen) begin
        msg_nxt  = edge_msg;
        once_nxt = 1'b0;
        prev_nxt = ctrl.level;
        if (ctrl.level) begin
          rel_nxt   = 32'd0;
          press_nxt = 32'd1;
        end else begin
          last_nxt  = press_r;
          press_nxt = 32'd0;
          rel_nxt   = 32'd1;
        end
      end else if (ctrl.level) begin
        press_nxt = press_sum[32] ? 32'hFFFF_FFFF : press_sum[31:0];
      end else begin
        rel_nxt = rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0];
      end
    end
    if (ctrl.set_once) begin
      once_nxt = 1'b1;
    end
    if (ctrl.load_blk) begin
      sup_nxt = ctrl.blk;
    end
    if (ctrl.clr_msg) begin
      msg_nxt = bcd_pkg::MSG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= '0;
      rel_r   <= '0;
      last_r  <= '0;
      sup_r   <= '0;
      prev_r  <= 1'b0;
      once_r  <= 1'b0;
      msg_r   <= bcd_pkg::MSG_NONE;
    end else begin
      press_r <= press_nxt;
      rel_r   <= rel_nxt;
      last_r  <= last_nxt;
      sup_r   <= sup_nxt;
      prev_r  <= prev_nxt;
      once_r  <= once_nxt;
      msg_r   <= msg_nxt;
    end
  end

  assign msg_o   = msg_r;
  assign press_o = press_r;
  assign last_o  = last_r;

endmodule

@@ rtl/bcd_rr_pick.sv @@
// Merge stage: round-robin search for the next lane with a posted message.
`timescale 1ns / 1ps
module bcd_rr_pick #(
  parameter int NUM_PINS = 8,
  parameter int PW       = 3
) (
  input  logic [NUM_PINS-1:0] vld,
  input  logic [PW-1:0]       ptr,
  output logic                found,
  output logic [PW-1:0]       sel
);

  always_comb begin
    logic [PW:0] cand;
    found = 1'b0;
    sel   = ptr;
    // Walk from the far end so the nearest hit to the pointer wins.
    for (int j = NUM_PINS - 1; j >= 0; j--) begin
      cand = {1'b0, ptr} + (PW+1)'(j);
      if (cand >= (PW+1)'(NUM_PINS)) begin
        cand = cand - (PW+1)'(NUM_PINS);
      end
      if (vld[cand[PW-1:0]]) begin
        found = 1'b1;
        sel   = cand[PW-1:0];
      end
    end
  end

endmodule

@@ rtl/bcd_out_buf.sv @@
// Two-entry result buffer that decouples the result side from the input side.
`timescale 1ns / 1ps
module bcd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bcd_pkg::result_t    push_data,
  output logic                space,
  output logic                out_valid,
  output bcd_pkg::result_t    out_data,
  input  logic                out_ready
);

  bcd_pkg::result_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign space     = count_r != 2'd2;
  assign out_valid = count_r != 2'd0;
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/button_click_detector.sv @@
// Top level of the button click and double-click detector.
// Each accepted input beat's result is registered into the result buffer.
// Throughput: one input beat per cycle while the result buffer has room.
// A two-entry result buffer keeps input beats flowing while results wait.
// Reset (synchronous, rst_n low) clears all timers, flags and messages and
// loads the double-click window with 200 ticks.
`timescale 1ns / 1ps
module button_click_detector #(
  parameter int NUM_PINS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  bcd_in_if.sink        in_ch,
  bcd_out_if.source     out_ch
);

  // Lane index width; a single lane still gets one bit.
  localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

  logic [15:0]          window_r;
  logic [PW-1:0]        scan_ptr_r, scan_ptr_nxt;
  logic [7:0]           mask_r, mask_nxt;

  logic                 accept;
  logic                 buf_space;
  bcd_pkg::mode_t       mode;
  logic                 is_tick, is_block, is_btime, is_fetch, is_query;
  logic                 pin_ok;
  logic [PW-1:0]        pin_sel;

  bcd_pkg::lane_ctrl_t  lane_ctrl [NUM_PINS];
  bcd_pkg::msg_t        lane_msg  [NUM_PINS];
  logic [31:0]          lane_press [NUM_PINS];
  logic [31:0]          lane_last  [NUM_PINS];
  logic [NUM_PINS-1:0]  msg_vld;
  logic [7:0]           pin_mask;

  logic                 pick_found;
  logic [PW-1:0]        pick_sel;

  bcd_pkg::result_t     res;
  bcd_pkg::result_t     buf_data;
  logic                 buf_valid;

  // Take a beat whenever the result buffer has room.
  assign in_ch.ready = buf_space;
  assign accept      = in_ch.valid && buf_space;

  assign mode     = bcd_pkg::mode_t'(in_ch.mode);
  assign is_tick  = mode == bcd_pkg::MODE_TICK;
  assign is_block = mode == bcd_pkg::MODE_BLOCK;
  assign is_btime = mode == bcd_pkg::MODE_BTIME;
  assign is_fetch = mode == bcd_pkg::MODE_FETCH;
  assign is_query = mode == bcd_pkg::MODE_QUERY;

  // Pin addresses past the last lane select nothing.
  assign pin_ok  = 32'(in_ch.pin_index) < 32'(NUM_PINS);
  assign pin_sel = PW'(in_ch.pin_index);

  // Per-pin lanes: each decodes its own share of the beat.
  for (genvar i = 0; i < NUM_PINS; i++) begin : g_lane
    logic lvl;
    logic hit;
    if (i < bcd_pkg::LEVEL_BITS) begin : g_lvl
      assign lvl = in_ch.pressed_levels[i];
    end else begin : g_nolvl
      assign lvl = 1'b0;
    end
    assign hit = accept && pin_ok && (32'(in_ch.pin_index) == 32'(i));

    always_comb begin
      lane_ctrl[i].tick     = accept && is_tick && (in_ch.elapsed_ticks != 16'd0);
      lane_ctrl[i].level    = lvl;
      lane_ctrl[i].dt       = in_ch.elapsed_ticks;
      lane_ctrl[i].window   = window_r;
      lane_ctrl[i].set_once = hit && is_block;
      lane_ctrl[i].load_blk = hit && is_btime;
      lane_ctrl[i].blk      = in_ch.block_ticks;
      lane_ctrl[i].clr_msg  = accept && is_fetch && pick_found
                              && (pick_sel == PW'(i));
    end

    bcd_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl[i]),
      .msg_o   (lane_msg[i]),
      .press_o (lane_press[i]),
      .last_o  (lane_last[i])
    );

    assign msg_vld[i] = lane_msg[i] != bcd_pkg::MSG_NONE;
  end

  // Only lanes that exist and have a level bit land in the mask.
  for (genvar b = 0; b < 8; b++) begin : g_pmask
    assign pin_mask[b] = b < NUM_PINS;
  end

  // Merge: find the next posted message starting at the scan pointer.
  bcd_rr_pick #(
    .NUM_PINS (NUM_PINS),
    .PW       (PW)
  ) u_pick (
    .vld   (msg_vld),
    .ptr   (scan_ptr_r),
    .found (pick_found),
    .sel   (pick_sel)
  );

  always_comb begin
    mask_nxt     = mask_r;
    scan_ptr_nxt = scan_ptr_r;
    if (accept && is_tick && (in_ch.elapsed_ticks != 16'd0)) begin
      mask_nxt = in_ch.pressed_levels & pin_mask;
    end
    // Park the pointer on the button just served.
    if (accept && is_fetch && pick_found) begin
      scan_ptr_nxt = pick_sel;
    end
  end

  // Result of the beat: mask after its update, all else from state before it.
  always_comb begin
    res.pressed_mask     = mask_nxt;
    res.msg_code         = bcd_pkg::MSG_NONE;
    res.msg_pin          = 3'd0;
    res.press_ticks_now  = 32'd0;
    res.press_ticks_last = 32'd0;
    if (is_fetch && pick_found) begin
      res.msg_code = lane_msg[pick_sel];
      res.msg_pin  = 3'(pick_sel);
    end
    if (is_query && pin_ok) begin
      res.press_ticks_now  = lane_press[pin_sel];
      res.press_ticks_last = lane_last[pin_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= bcd_pkg::DBL_WINDOW_RESET;
      scan_ptr_r <= '0;
      mask_r     <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      scan_ptr_r <= scan_ptr_nxt;
      mask_r     <= mask_nxt;
    end
  end

  bcd_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (res),
    .space     (buf_space),
    .out_valid (buf_valid),
    .out_data  (buf_data),
    .out_ready (out_ch.ready)
  );

  assign out_ch.valid            = buf_valid;
  assign out_ch.pressed_mask     = buf_data.pressed_mask;
  assign out_ch.msg_code         = buf_data.msg_code;
  assign out_ch.msg_pin          = buf_data.msg_pin;
  assign out_ch.press_ticks_now  = buf_data.press_ticks_now;
  assign out_ch.press_ticks_last = buf_data.press_ticks_last;

`ifndef NO_ASSERTIONS
  // A served message is gone from its lane after the fetch beat.
  a_fetch_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_fetch && pick_found |=> !msg_vld[$past(pick_sel)])
    else $error("fetched message still posted");

  // A tick with zero elapsed does not resample the mask.
  a_zero_tick_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_tick && (in_ch.elapsed_ticks == 16'd0) |=> $stable(mask_r))
    else $error("mask changed on zero-elapsed tick");

  // The scan pointer always addresses an existing lane.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(scan_ptr_r) < 32'(NUM_PINS))
    else $error("scan pointer out of range");

  // No beat is taken when the buffer is full; a full, undrained one stays valid.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    buf_valid && !out_ch.ready && !buf_space |=> buf_valid)
    else $error("result buffer lost a beat");
`endif

endmodule
